FILE: hw/rtl/gpioirq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpioirq_pkg
// shared types, command codes and register offsets of the gpio bank block
// ----------------------------------------------------------------------------
package gpioirq_pkg;

    // default configuration
    localparam int NUM_BANKS_DEF     = 2;
    localparam int PINS_PER_BANK_DEF = 32;

    // command codes
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // register offsets
    localparam logic [3:0] REG_DIR     = 4'd0;
    localparam logic [3:0] REG_DATAIN  = 4'd1;
    localparam logic [3:0] REG_DATAOUT = 4'd2;
    localparam logic [3:0] REG_SET     = 4'd3;
    localparam logic [3:0] REG_CLEAR   = 4'd4;
    localparam logic [3:0] REG_IRQSTAT = 4'd5;
    localparam logic [3:0] REG_IRQEN   = 4'd6;
    localparam logic [3:0] REG_RISE    = 4'd7;
    localparam logic [3:0] REG_FALL    = 4'd8;
    localparam logic [3:0] REG_LOW     = 4'd9;
    localparam logic [3:0] REG_HIGH    = 4'd10;

    // request word
    typedef struct packed {
        logic [1:0]  command;
        logic        bank;
        logic [3:0]  reg_index;
        logic [31:0] write_data;
        logic [31:0] pin_levels;
    } t_in_word;

    // response word
    typedef struct packed {
        logic [31:0] read_data;
        logic [31:0] pin_out;
        logic [31:0] pin_drive;
        logic [1:0]  irq_lines;
    } t_out_word;

endpackage

FILE: hw/rtl/gpio_bank_with_edge_level_irq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpio_bank_with_edge_level_irq
// banked gpio register file with edge and level interrupt detection
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  request   in         i_in_valid / o_in_stall   i_in_word  (t_in_word)
//  response  out        o_out_valid / i_out_stall o_out_word (t_out_word)
//
// one word per clock while the request stall is low: a request updates the
// bank registers and forms its response in the cycle it is accepted
// a skid register behind the response register takes one more word while
// the response is stalled; request stall rises only when the skid is full
// reset (synchronous, active low) sets every direction bit (all pins input),
// clears all other bank registers and empties both response registers
//
module gpio_bank_with_edge_level_irq #(
    parameter int NUM_BANKS     = gpioirq_pkg::NUM_BANKS_DEF,
    parameter int PINS_PER_BANK = gpioirq_pkg::PINS_PER_BANK_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  gpioirq_pkg::t_in_word i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output gpioirq_pkg::t_out_word o_out_word
);

    localparam int P = PINS_PER_BANK;

    // per bank register file
    logic [P-1:0] r_dir    [NUM_BANKS];
    logic [P-1:0] r_dout   [NUM_BANKS];
    logic [P-1:0] r_din    [NUM_BANKS];
    logic [P-1:0] r_prev   [NUM_BANKS];
    logic [P-1:0] r_irq_en [NUM_BANKS];
    logic [P-1:0] r_irq_st [NUM_BANKS];
    logic [P-1:0] r_rise   [NUM_BANKS];
    logic [P-1:0] r_fall   [NUM_BANKS];
    logic [P-1:0] r_low    [NUM_BANKS];
    logic [P-1:0] r_high   [NUM_BANKS];

    logic [P-1:0] n_dir    [NUM_BANKS];
    logic [P-1:0] n_dout   [NUM_BANKS];
    logic [P-1:0] n_din    [NUM_BANKS];
    logic [P-1:0] n_prev   [NUM_BANKS];
    logic [P-1:0] n_irq_en [NUM_BANKS];
    logic [P-1:0] n_irq_st [NUM_BANKS];
    logic [P-1:0] n_rise   [NUM_BANKS];
    logic [P-1:0] n_fall   [NUM_BANKS];
    logic [P-1:0] n_low    [NUM_BANKS];
    logic [P-1:0] n_high   [NUM_BANKS];

    // response side: output register plus one skid entry
    logic                   r_out_valid;
    gpioirq_pkg::t_out_word r_out;
    logic                   r_skid_valid;
    gpioirq_pkg::t_out_word r_skid;

    logic                   w_in_acc;
    logic                   w_out_fire;
    gpioirq_pkg::t_out_word w_resp;

    assign o_in_stall  = r_skid_valid;
    assign w_in_acc    = i_in_valid && !r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;
    assign w_out_fire  = r_out_valid && !i_out_stall;

    // next bank state and response word
    always_comb begin
        logic [P-1:0] v_wd;
        logic [P-1:0] v_pl;
        logic [P-1:0] v_ev;
        logic         v_hit;

        v_wd = i_in_word.write_data[P-1:0];
        v_pl = i_in_word.pin_levels[P-1:0];
        v_ev = '0;

        n_dir    = r_dir;
        n_dout   = r_dout;
        n_din    = r_din;
        n_prev   = r_prev;
        n_irq_en = r_irq_en;
        n_irq_st = r_irq_st;
        n_rise   = r_rise;
        n_fall   = r_fall;
        n_low    = r_low;
        n_high   = r_high;

        w_resp = '0;

        for (int k = 0; k < NUM_BANKS; k++) begin
            // a bank beyond the configured count is never hit
            v_hit = (2'(k) == {1'b0, i_in_word.bank});
            if (v_hit) begin
                case (i_in_word.command)
                    gpioirq_pkg::CMD_READ: begin
                        case (i_in_word.reg_index)
                            gpioirq_pkg::REG_DIR:     w_resp.read_data = 32'(r_dir[k]);
                            gpioirq_pkg::REG_DATAIN:  w_resp.read_data = 32'(r_din[k]);
                            gpioirq_pkg::REG_DATAOUT,
                            gpioirq_pkg::REG_SET,
                            gpioirq_pkg::REG_CLEAR:   w_resp.read_data = 32'(r_dout[k]);
                            gpioirq_pkg::REG_IRQSTAT: w_resp.read_data = 32'(r_irq_st[k]);
                            gpioirq_pkg::REG_IRQEN:   w_resp.read_data = 32'(r_irq_en[k]);
                            gpioirq_pkg::REG_RISE:    w_resp.read_data = 32'(r_rise[k]);
                            gpioirq_pkg::REG_FALL:    w_resp.read_data = 32'(r_fall[k]);
                            gpioirq_pkg::REG_LOW:     w_resp.read_data = 32'(r_low[k]);
                            gpioirq_pkg::REG_HIGH:    w_resp.read_data = 32'(r_high[k]);
                            default:                  w_resp.read_data = '0;
                        endcase
                    end
                    gpioirq_pkg::CMD_WRITE: begin
                        // data in is read only, unknown offsets are dropped
                        case (i_in_word.reg_index)
                            gpioirq_pkg::REG_DIR:     n_dir[k]    = v_wd;
                            gpioirq_pkg::REG_DATAOUT: n_dout[k]   = v_wd;
                            gpioirq_pkg::REG_SET:     n_dout[k]   = r_dout[k] | v_wd;
                            gpioirq_pkg::REG_CLEAR:   n_dout[k]   = r_dout[k] & ~v_wd;
                            gpioirq_pkg::REG_IRQSTAT: n_irq_st[k] = r_irq_st[k] & ~v_wd;
                            gpioirq_pkg::REG_IRQEN:   n_irq_en[k] = r_irq_en[k] | v_wd;
                            gpioirq_pkg::REG_RISE:    n_rise[k]   = v_wd;
                            gpioirq_pkg::REG_FALL:    n_fall[k]   = v_wd;
                            gpioirq_pkg::REG_LOW:     n_low[k]    = v_wd;
                            gpioirq_pkg::REG_HIGH:    n_high[k]   = v_wd;
                            default: ;
                        endcase
                    end
                    gpioirq_pkg::CMD_TICK: begin
                        v_ev = (r_rise[k] & v_pl & ~r_prev[k])
                             | (r_fall[k] & r_prev[k] & ~v_pl)
                             | (r_low[k] & ~v_pl)
                             | (r_high[k] & v_pl);
                        n_irq_st[k] = r_irq_st[k] | (v_ev & r_irq_en[k]);
                        n_din[k]    = v_pl;
                        n_prev[k]   = v_pl;
                    end
                    default: ;
                endcase
                w_resp.pin_out   = 32'(n_dout[k]);
                w_resp.pin_drive = 32'(~n_dir[k]);
            end
        end

        // only the first two banks have a line in the response
        for (int k = 0; k < NUM_BANKS && k < 2; k++) begin
            w_resp.irq_lines[k] = |n_irq_st[k];
        end
    end

    // bank registers change only on an accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_BANKS; k++) begin
                r_dir[k]    <= '1;
                r_dout[k]   <= '0;
                r_din[k]    <= '0;
                r_prev[k]   <= '0;
                r_irq_en[k] <= '0;
                r_irq_st[k] <= '0;
                r_rise[k]   <= '0;
                r_fall[k]   <= '0;
                r_low[k]    <= '0;
                r_high[k]   <= '0;
            end
        end else if (w_in_acc) begin
            r_dir    <= n_dir;
            r_dout   <= n_dout;
            r_din    <= n_din;
            r_prev   <= n_prev;
            r_irq_en <= n_irq_en;
            r_irq_st <= n_irq_st;
            r_rise   <= n_rise;
            r_fall   <= n_fall;
            r_low    <= n_low;
            r_high   <= n_high;
        end
    end

    // response register and skid entry, handshake control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // no request taken while the skid is full
            if (w_out_fire) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_in_acc) begin
            if (r_out_valid && !w_out_fire) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (w_out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload moves, no reset needed
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_out_fire) begin
                r_out <= r_skid;
            end
        end else if (w_in_acc) begin
            if (r_out_valid && !w_out_fire) begin
                r_skid <= w_resp;
            end else begin
                r_out <= w_resp;
            end
        end
    end

endmodule
